/* rtl/iabd_pkg.sv */
// Shared types, constants and tables for the IMA ADPCM block decoder.
// Holds the standard IMA step-size table and index-adjust rule.
// No dependencies; imported by iabd_nibble_decode and the top level.
`default_nettype none

package iabd_pkg;

   localparam int unsigned BlockBytesW = 13;
   localparam int unsigned StepMax     = 88;

   typedef logic [6:0]         step_idx_type;
   typedef logic signed [15:0] sample_type;

   typedef struct packed {
      sample_type   pred;
      step_idx_type idx;
   } dec_state_type;

   localparam logic [14:0] StepTable [0:88] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
      15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
      15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
      15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
      15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
      15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
      15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
      15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
      15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
      15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
      15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
      15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
      15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
   };

   function automatic step_idx_type clamp_idx(input step_idx_type idx);
      if (idx > step_idx_type'(StepMax)) begin
         return step_idx_type'(StepMax);
      end
      return idx;
   endfunction

   function automatic logic [14:0] step_size(input step_idx_type idx);
      return StepTable[clamp_idx(idx)];
   endfunction

   // Codes 0..3 step the index down by one; codes 4..7 step it up by 2, 4, 6 or 8.
   function automatic logic signed [4:0] index_move(input logic [2:0] code);
      if (code[2]) begin
         return $signed({2'b00, code[1:0], 1'b0}) + 5'sd2;
      end
      return -5'sd1;
   endfunction

endpackage

`default_nettype wire

/* rtl/ima_adpcm_block_decoder_core.sv */
// IMA ADPCM mono block decoder: one byte per input beat, PCM samples out.
// Depends on iabd_pkg and iabd_nibble_decode.
//
// Usage:
// The req channel carries the raw block stream, one byte per beat. The rsp
// channel carries 16-bit two's complement samples; rsp_tlast marks the last
// sample of a block. The csr port sets the block length in bytes, header
// included; the user must write it only while the decoder is idle, unchecked.
// Header bytes 0 to 2 load the predictor and step index and give no beat.
// Byte 3 gives the predictor as the first sample; every later byte gives
// two samples, low nibble first.
// The first sample of a byte passes the work stage and then the output
// register before it is on rsp. A data byte holds the work stage for both
// nibbles, since one nibble decoder serves both nibbles in turn, so the
// next byte is taken only once the high nibble is decoded.
// The work stage and the output register are separate, so a new byte is
// taken while a finished sample waits. A stall on rsp_tready holds the
// output and then the work stage, which drops req_tready.
// Reset clears the byte counter, predictor and step index and sets the
// block length to 256.
`default_nettype none

module ima_adpcm_block_decoder_core #(
   parameter int unsigned MAX_BLOCK_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [15:0] sample
   output logic        rsp_tlast
);
   import iabd_pkg::*;

   localparam int unsigned PosW    = $clog2(MAX_BLOCK_BYTES);
   localparam int unsigned LenBits = $clog2(MAX_BLOCK_BYTES + 1);
   localparam int unsigned LenW    = (LenBits > BlockBytesW) ? LenBits : BlockBytesW;
   localparam logic [LenW-1:0] MaxLen = LenW'(MAX_BLOCK_BYTES);
   localparam logic [LenW-1:0] MinLen = LenW'(4);

   typedef enum logic [2:0] {
      KIND_HDR_LO,
      KIND_HDR_HI,
      KIND_STEP,
      KIND_FIRST,
      KIND_DATA
   } kind_type;

   logic [12:0]     blen_ff;
   logic [PosW-1:0] pos_ff;
   dec_state_type   state_ff;
   logic [7:0]      hdr_lo_ff;
   logic            work_vld_ff;
   logic            work_hi_ff;
   kind_type        work_kind_ff;
   logic [7:0]      work_byte_ff;
   logic            work_last_ff;
   logic            rsp_vld_ff;
   sample_type      rsp_data_ff;
   logic            rsp_last_ff;

   logic [LenW-1:0] len_raw;
   logic [LenW-1:0] len_eff;
   logic [LenW-1:0] pos_inc;
   logic            is_last;
   kind_type        kind_in;
   logic            out_free;
   logic            needs_out;
   logic            step_en;
   logic            work_done;
   logic            accept;
   logic [3:0]      nibble;
   dec_state_type   nib_state;

   iabd_nibble_decode u_nibble (
      .state_in  (state_ff),
      .code      (nibble),
      .state_out (nib_state)
   );

   always_comb begin
      len_raw = LenW'(blen_ff);
      if (len_raw < MinLen) begin
         len_eff = MinLen;
      end else if (len_raw > MaxLen) begin
         len_eff = MaxLen;
      end else begin
         len_eff = len_raw;
      end
      pos_inc = LenW'(pos_ff) + LenW'(1);
      is_last = (pos_inc >= len_eff);

      if (pos_ff == PosW'(0)) begin
         kind_in = KIND_HDR_LO;
      end else if (pos_ff == PosW'(1)) begin
         kind_in = KIND_HDR_HI;
      end else if (pos_ff == PosW'(2)) begin
         kind_in = KIND_STEP;
      end else if (pos_ff == PosW'(3)) begin
         kind_in = KIND_FIRST;
      end else begin
         kind_in = KIND_DATA;
      end

      out_free   = !rsp_vld_ff || rsp_tready;
      needs_out  = (work_kind_ff == KIND_FIRST) || (work_kind_ff == KIND_DATA);
      step_en    = work_vld_ff && (!needs_out || out_free);
      work_done  = step_en && ((work_kind_ff != KIND_DATA) || work_hi_ff);
      req_tready = !work_vld_ff || work_done;
      accept     = req_tvalid && req_tready;
      nibble     = work_hi_ff ? work_byte_ff[7:4] : work_byte_ff[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blen_ff     <= 13'd256;
         pos_ff      <= '0;
         state_ff    <= '0;
         hdr_lo_ff   <= '0;
         work_vld_ff <= 1'b0;
         work_hi_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            blen_ff <= csr_wr_data;
         end

         if (accept) begin
            pos_ff <= is_last ? '0 : pos_inc[PosW-1:0];
         end

         if (accept) begin
            work_vld_ff <= 1'b1;
         end else if (work_done) begin
            work_vld_ff <= 1'b0;
         end

         if (accept) begin
            work_hi_ff <= 1'b0;
         end else if (step_en && (work_kind_ff == KIND_DATA)) begin
            work_hi_ff <= 1'b1;
         end

         if (step_en) begin
            unique case (work_kind_ff)
               KIND_HDR_LO: hdr_lo_ff <= work_byte_ff;
               KIND_HDR_HI: state_ff.pred <= sample_type'({work_byte_ff, hdr_lo_ff});
               KIND_STEP: begin
                  if (work_byte_ff > 8'(StepMax)) begin
                     state_ff.idx <= step_idx_type'(StepMax);
                  end else begin
                     state_ff.idx <= work_byte_ff[6:0];
                  end
               end
               KIND_FIRST: state_ff <= state_ff;
               KIND_DATA:  state_ff <= nib_state;
               default:    state_ff <= state_ff;
            endcase
         end

         if (step_en && needs_out) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         work_kind_ff <= kind_in;
         work_byte_ff <= req_tdata;
         work_last_ff <= is_last;
      end
      if (step_en && needs_out) begin
         rsp_data_ff <= (work_kind_ff == KIND_FIRST) ? state_ff.pred : nib_state.pred;
         rsp_last_ff <= work_last_ff && ((work_kind_ff == KIND_FIRST) || work_hi_ff);
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_pos_in_range : assert property (@(posedge clock) disable iff (reset)
      LenW'(pos_ff) < MaxLen)
      else $error("byte counter beyond maximum block length");

   a_idx_in_range : assert property (@(posedge clock) disable iff (reset)
      state_ff.idx <= step_idx_type'(StepMax))
      else $error("step index beyond table");

   a_accept_loads : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> work_vld_ff)
      else $error("accepted byte did not reach the work stage");

   a_no_drop : assert property (@(posedge clock) disable iff (reset)
      (step_en && needs_out) |-> (!rsp_vld_ff || rsp_tready))
      else $error("sample written over a waiting one");
`endif

endmodule

`default_nettype wire

/* rtl/iabd_nibble_decode.sv */
// Combinational decode of one 4-bit IMA ADPCM code.
// Takes the predictor and step index, returns their updated values.
// Depends on iabd_pkg for the step table and the state type.
`default_nettype none

module iabd_nibble_decode (
   input  iabd_pkg::dec_state_type state_in,
   input  logic [3:0]              code,
   output iabd_pkg::dec_state_type state_out
);
   import iabd_pkg::*;

   step_idx_type       idx_cur;
   logic [14:0]        step;
   logic [15:0]        diff;
   logic signed [17:0] sum;
   logic signed [7:0]  idx_sum;

   always_comb begin
      idx_cur = clamp_idx(state_in.idx);
      step    = step_size(idx_cur);
      diff    = {4'b0000, step[14:3]};
      if (code[0]) begin
         diff = diff + {3'b000, step[14:2]};
      end
      if (code[1]) begin
         diff = diff + {2'b00, step[14:1]};
      end
      if (code[2]) begin
         diff = diff + {1'b0, step};
      end

      if (code[3]) begin
         sum = {{2{state_in.pred[15]}}, state_in.pred} - $signed({2'b00, diff});
      end else begin
         sum = {{2{state_in.pred[15]}}, state_in.pred} + $signed({2'b00, diff});
      end

      if (sum > 18'sd32767) begin
         state_out.pred = 16'sh7FFF;
      end else if (sum < -18'sd32768) begin
         state_out.pred = 16'sh8000;
      end else begin
         state_out.pred = sum[15:0];
      end

      idx_sum = $signed({1'b0, idx_cur}) + 8'(index_move(code[2:0]));
      if (idx_sum < 8'sd0) begin
         state_out.idx = '0;
      end else if (idx_sum > $signed(8'(StepMax))) begin
         state_out.idx = step_idx_type'(StepMax);
      end else begin
         state_out.idx = idx_sum[6:0];
      end
   end

endmodule

`default_nettype wire
